FILE: rtl/core/sbm_pkg.sv
// Package for the sparse block map translator.
// Holds the shared types, codes and marker constants; no dependencies.
package sbm_pkg;

  localparam logic [31:0] FREE_MARK = 32'hFFFF_FFFF;
  localparam logic [31:0] ZERO_MARK = 32'hFFFF_FFFE;
  localparam logic [4:0]  LG_MIN    = 5'd9;
  localparam logic [4:0]  LG_MAX    = 5'd20;
  localparam logic [4:0]  LG_RESET  = 5'd20;

  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_LOAD  = 2'd2,
    ACT_SETC  = 2'd3
  } act_t;

  typedef enum logic [2:0] {
    K_HOLE  = 3'd0,
    K_ZFILL = 3'd1,
    K_RMAP  = 3'd2,
    K_MZERO = 3'd3,
    K_WMAP  = 3'd4,
    K_ALLOC = 3'd5,
    K_ERR   = 3'd6,
    K_ACK   = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    CFG_BSIZE = 2'd0,
    CFG_DOFF  = 2'd1,
    CFG_BTOT  = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_END,
    S_LST,
    S_CHK,
    S_RD,
    S_ENT,
    S_PHY,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [4:0]  lg;
    logic [31:0] data_offset;
    logic [12:0] total;
  } cfg_t;

endpackage

FILE: rtl/core/sbm_if.sv
// Channel interfaces for the sparse block map translator.
// Request, result and configuration channels; depends on sbm_pkg.
interface sbm_req_if;
  import sbm_pkg::*;
  logic        valid;
  logic        ready;
  act_t        action;
  logic [31:0] byte_offset;
  logic [24:0] byte_length;
  logic [15:0] zero_mask;
  logic [11:0] map_index;
  logic [31:0] entry_value;
  modport source (output valid, action, byte_offset, byte_length, zero_mask, map_index,
                  entry_value, input ready);
  modport sink (input valid, action, byte_offset, byte_length, zero_mask, map_index,
                entry_value, output ready);
endinterface

interface sbm_res_if;
  import sbm_pkg::*;
  logic        valid;
  logic        ready;
  kind_t       segment_kind;
  logic [32:0] physical_offset;
  logic [20:0] segment_length;
  logic [11:0] virtual_block;
  logic [12:0] allocated_count;
  logic        last_segment;
  modport source (output valid, segment_kind, physical_offset, segment_length,
                  virtual_block, allocated_count, last_segment, input ready);
  modport sink (input valid, segment_kind, physical_offset, segment_length,
                virtual_block, allocated_count, last_segment, output ready);
endinterface

interface sbm_cfg_if;
  import sbm_pkg::*;
  logic        valid;
  logic        ready;
  cfg_idx_t    index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/sbm_addu.sv
// Shared 34-bit adder with carry in, used for every wide sum and difference.
// No dependencies.
module sbm_addu (
  input  logic [33:0] a,
  input  logic [33:0] b,
  input  logic        cin,
  output logic [33:0] sum
);
  assign sum = a + b + {33'b0, cin};
endmodule

FILE: rtl/core/sbm_map.sv
// Block map memory: one write port and one registered read port.
// No dependencies.
module sbm_map #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);
  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/core/sbm_ctrl.sv
// Sequencer of the translator: splits requests into block segments and drives
// the shared adder and the block map. Depends on sbm_pkg, sbm_if, sbm_addu, sbm_map.
module sbm_ctrl #(
  parameter int MAP_BLOCKS   = 4096,
  parameter int MAX_SEGMENTS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  sbm_pkg::cfg_t cfg,
  sbm_req_if.sink      req,
  sbm_res_if.source    res
);
  import sbm_pkg::*;

  localparam int AW = (MAP_BLOCKS > 1) ? $clog2(MAP_BLOCKS) : 1;
  localparam int SegLimit = (MAX_SEGMENTS < 16) ? MAX_SEGMENTS : 16;
  localparam logic [12:0] AllocMax = 13'((MAP_BLOCKS < 8191) ? MAP_BLOCKS : 8191);

  state_t state, state_next;

  act_t        act_r;
  logic [31:0] off_r;
  logic [24:0] len_r;
  logic [15:0] mask_r;
  logic [33:0] end_r;
  logic [23:0] first_r;
  logic [24:0] lastb_r;
  logic [32:0] pos_r;
  logic [3:0]  seg_r;
  logic [11:0] blk_r;
  logic [AW-1:0] blk_addr_r;
  logic [19:0] inblk_r;
  logic [20:0] slen_r;
  logic        last_r;
  logic [32:0] base_r;
  kind_t       out_kind;
  logic [32:0] out_phys;
  logic [20:0] out_len;
  logic [11:0] out_vblk;
  logic        out_last;
  logic [12:0] alloc_count;
  logic [AW-1:0] clr_addr;

  logic [33:0] add_a, add_b, add_sum;
  logic        add_cin;
  logic        mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [31:0] mem_wdata, rdata;

  logic        accept, midx_bad, len0, range_err, span_err;
  logic        ent_free, ent_zero, ent_hz, zero_data, full, full_err, alloc_now;
  logic [31:0] ent_sel;
  logic [32:0] ent_shift;
  kind_t       ent_kind;
  logic [20:0] bsize, slen_full;
  logic [19:0] lowmask, inblk;
  logic [12:0] set_val;

  sbm_addu u_addu (.a(add_a), .b(add_b), .cin(add_cin), .sum(add_sum));

  sbm_map #(.DEPTH(MAP_BLOCKS), .AW(AW)) u_map (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(rdata)
  );

  assign accept    = (state == S_IDLE) && req.valid;
  assign midx_bad  = 17'(req.map_index) >= 17'(MAP_BLOCKS);
  assign set_val   = (req.entry_value > 32'(AllocMax)) ? AllocMax : req.entry_value[12:0];
  assign len0      = (len_r == 25'd0);
  assign range_err = lastb_r >= 25'(cfg.total);
  assign span_err  = add_sum >= 34'(SegLimit);

  assign bsize     = 21'd1 << cfg.lg;
  assign lowmask   = ~(20'hFFFFF << cfg.lg);
  assign inblk     = pos_r[19:0] & lowmask;
  assign slen_full = bsize - 21'(inblk);

  assign ent_free  = (rdata == FREE_MARK);
  assign ent_zero  = (rdata == ZERO_MARK);
  assign ent_hz    = ent_free || ent_zero;
  assign zero_data = mask_r[seg_r];
  assign full      = alloc_count >= cfg.total;
  assign full_err  = (act_r == ACT_WRITE) && ent_hz && !zero_data && full;
  assign alloc_now = (act_r == ACT_WRITE) && ent_hz && !zero_data && !full;
  assign ent_sel   = ((act_r == ACT_WRITE) && ent_hz) ? 32'(alloc_count) : rdata;
  assign ent_shift = {1'b0, ent_sel} << cfg.lg;

  always_comb begin
    if (act_r == ACT_READ) begin
      ent_kind = ent_free ? K_HOLE : (ent_zero ? K_ZFILL : K_RMAP);
    end else if (ent_hz) begin
      ent_kind = zero_data ? K_MZERO : (full ? K_ERR : K_ALLOC);
    end else begin
      ent_kind = K_WMAP;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLR: begin
        if (clr_addr == AW'(MAP_BLOCKS - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req.valid) begin
          state_next = (req.action == ACT_READ || req.action == ACT_WRITE) ? S_END : S_OUT;
        end
      end
      S_END: state_next = S_LST;
      S_LST: state_next = S_CHK;
      S_CHK: state_next = (len0 || range_err || span_err) ? S_OUT : S_RD;
      S_RD:  state_next = S_ENT;
      S_ENT: state_next = S_PHY;
      S_PHY: state_next = S_OUT;
      S_OUT: begin
        if (res.ready) state_next = out_last ? S_IDLE : S_RD;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    add_a     = '0;
    add_b     = '0;
    add_cin   = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = blk_addr_r;
    mem_wdata = ZERO_MARK;
    mem_raddr = AW'(pos_r >> cfg.lg);
    req.ready = (state == S_IDLE);
    res.valid = (state == S_OUT);
    unique case (state)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = FREE_MARK;
      end
      S_IDLE: begin
        if (req.valid && req.action == ACT_LOAD && !midx_bad) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(req.map_index);
          mem_wdata = req.entry_value;
        end
      end
      S_END: begin
        add_a = 34'(off_r);
        add_b = 34'(len_r);
      end
      S_LST: begin
        add_a = end_r;
        add_b = '1;
      end
      S_CHK: begin
        add_a   = 34'(lastb_r);
        add_b   = ~34'(first_r);
        add_cin = 1'b1;
      end
      S_RD: begin
        add_a   = end_r;
        add_b   = ~34'(pos_r);
        add_cin = 1'b1;
      end
      S_ENT: begin
        add_a = 34'(ent_shift);
        add_b = 34'(cfg.data_offset);
        if ((act_r == ACT_WRITE) && ent_hz && zero_data) begin
          mem_we    = 1'b1;
          mem_wdata = ZERO_MARK;
        end else if (alloc_now) begin
          mem_we    = 1'b1;
          mem_wdata = 32'(alloc_count);
        end
      end
      S_PHY: begin
        add_a = 34'(base_r);
        add_b = 34'(inblk_r);
      end
      S_OUT: begin
        add_a = 34'(pos_r);
        add_b = 34'(out_len);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLR;
      clr_addr    <= '0;
      alloc_count <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLR) clr_addr <= clr_addr + AW'(1);
      if (accept && req.action == ACT_SETC) alloc_count <= set_val;
      if (state == S_ENT && alloc_now) alloc_count <= alloc_count + 13'd1;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        act_r    <= req.action;
        off_r    <= req.byte_offset;
        len_r    <= req.byte_length;
        mask_r   <= req.zero_mask;
        out_phys <= '0;
        out_len  <= '0;
        out_last <= 1'b1;
        if (req.action == ACT_LOAD) begin
          out_kind <= midx_bad ? K_ERR : K_ACK;
          out_vblk <= req.map_index;
        end else begin
          out_kind <= K_ACK;
          out_vblk <= '0;
        end
      end
      S_END: end_r <= add_sum;
      S_LST: begin
        lastb_r <= 25'(add_sum[32:0] >> cfg.lg);
        first_r <= 24'(off_r >> cfg.lg);
        pos_r   <= 33'(off_r);
        seg_r   <= '0;
      end
      S_CHK: begin
        out_phys <= '0;
        out_len  <= '0;
        out_last <= 1'b1;
        out_kind <= len0 ? K_ACK : K_ERR;
        out_vblk <= len0 ? 12'd0 : first_r[11:0];
      end
      S_RD: begin
        blk_r      <= 12'(pos_r >> cfg.lg);
        blk_addr_r <= AW'(pos_r >> cfg.lg);
        inblk_r    <= inblk;
        slen_r     <= (add_sum < 34'(slen_full)) ? add_sum[20:0] : slen_full;
        last_r     <= (add_sum <= 34'(slen_full));
      end
      S_ENT: begin
        base_r   <= add_sum[32:0];
        out_kind <= ent_kind;
        out_vblk <= blk_r;
        out_len  <= full_err ? 21'd0 : slen_r;
        out_last <= full_err || last_r;
      end
      S_PHY: begin
        out_phys <= (out_kind inside {K_RMAP, K_WMAP, K_ALLOC}) ? add_sum[32:0] : 33'd0;
      end
      S_OUT: begin
        if (res.ready) begin
          pos_r <= add_sum[32:0];
          seg_r <= seg_r + 4'd1;
        end
      end
      default: ;
    endcase
  end

  assign res.segment_kind    = out_kind;
  assign res.physical_offset = out_phys;
  assign res.segment_length  = out_len;
  assign res.virtual_block   = out_vblk;
  assign res.allocated_count = alloc_count;
  assign res.last_segment    = out_last;

endmodule

FILE: rtl/core/sparse_block_map_translator_top.sv
// Top level of the sparse block map translator: configuration registers and
// the sequencer. Depends on sbm_pkg, sbm_if and sbm_ctrl.
//
// Requests arrive on req (read, write, load map entry, set allocated count);
// each read or write yields one result per block segment on res, the last one
// flagged by last_segment. Registers must be written by the user on cfg only
// while the block is idle; the block itself does not enforce this. After reset
// the block map is swept to the free marker, one entry per cycle; req.ready
// stays low until the sweep ends. A load or set request goes from idle straight
// to the result state for its ack. A read or write passes setup (offset sum,
// last block, range and span checks) and then, per segment, map read, entry
// decode with base offset, final offset add and the result, all on one shared
// 34-bit adder and the one block map. One request is in work at a time and
// req.ready is high only when idle. When the receiver stalls, the result is
// held in the output register and the sequencer waits.
module sparse_block_map_translator_top #(
  parameter int MAP_BLOCKS   = 4096,
  parameter int MAX_SEGMENTS = 16
) (
  input  logic      clk,
  input  logic      rst,
  sbm_req_if.sink   req,
  sbm_res_if.source res,
  sbm_cfg_if.sink   cfg
);
  import sbm_pkg::*;

  localparam logic [16:0] MapBlk = 17'(MAP_BLOCKS);

  cfg_t        cfg_q;
  logic [4:0]  lg_in;

  assign cfg.ready = 1'b1;
  assign lg_in = (cfg.data[4:0] < LG_MIN) ? LG_MIN :
                 ((cfg.data[4:0] > LG_MAX) ? LG_MAX : cfg.data[4:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.lg          <= LG_RESET;
      cfg_q.data_offset <= '0;
      cfg_q.total       <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_BSIZE: cfg_q.lg <= lg_in;
        CFG_DOFF:  cfg_q.data_offset <= cfg.data;
        CFG_BTOT: begin
          cfg_q.total <= (17'(cfg.data[12:0]) > MapBlk) ? MapBlk[12:0] : cfg.data[12:0];
        end
        default: ;
      endcase
    end
  end

  sbm_ctrl #(.MAP_BLOCKS(MAP_BLOCKS), .MAX_SEGMENTS(MAX_SEGMENTS)) u_ctrl (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_q),
    .req(req),
    .res(res)
  );

endmodule

FILE: test/tb.sv
// Testbench for sparse_block_map_translator_top: directed and random read, write,
// load and set-count requests, checked against a predictor of the block map.
// Depends on sbm_pkg, sbm_if and the translator RTL.
module tb;
  import sbm_pkg::*;

  localparam int MAP_BLOCKS  = 4096;
  localparam int SEG_LIMIT   = 16;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    act_t        action;
    logic [31:0] byte_offset;
    logic [24:0] byte_length;
    logic [15:0] zero_mask;
    logic [11:0] map_index;
    logic [31:0] entry_value;
  } map_req_t;

  typedef struct packed {
    kind_t       kind;
    logic [32:0] phys;
    logic [20:0] len;
    logic [11:0] vblk;
    logic [12:0] count;
    logic        last;
  } segment_t;

  class segment_scoreboard;
    logic [31:0] block_map [MAP_BLOCKS];
    logic [12:0] alloc_count;
    logic [4:0]  lg_reg;
    logic [31:0] doff_reg;
    logic [12:0] total_reg;
    segment_t    expected_segments [$];
    int          mismatches;

    function new();
      foreach (block_map[i]) block_map[i] = FREE_MARK;
      alloc_count = '0;
      lg_reg      = LG_RESET;
      doff_reg    = '0;
      total_reg   = '0;
      mismatches  = 0;
    endfunction

    function void set_register(cfg_idx_t idx, logic [31:0] data);
      case (idx)
        CFG_BSIZE: lg_reg = data[4:0];
        CFG_DOFF:  doff_reg = data;
        CFG_BTOT:  total_reg = data[12:0];
        default: ;
      endcase
    endfunction

    function int unsigned block_log2();
      return (lg_reg < LG_MIN) ? LG_MIN : ((lg_reg > LG_MAX) ? LG_MAX : lg_reg);
    endfunction

    function int unsigned disk_blocks();
      return (total_reg > MAP_BLOCKS) ? MAP_BLOCKS : total_reg;
    endfunction

    function logic [63:0] image_offset(logic [31:0] pblk, int unsigned lg, logic [63:0] inblk);
      return ({32'b0, pblk} << lg) + {32'b0, doff_reg} + inblk;
    endfunction

    function void expect_segment(kind_t kind, logic [63:0] phys, logic [63:0] len,
                                 logic [63:0] vblk, logic last);
      segment_t s;
      s.kind  = kind;
      s.phys  = phys[32:0];
      s.len   = len[20:0];
      s.vblk  = vblk[11:0];
      s.count = alloc_count;
      s.last  = last;
      expected_segments.push_back(s);
    endfunction

    function void note_request(map_req_t r);
      int unsigned lg, total, seg;
      logic [63:0] bsize, first, lastb, pos, stop, blk, inblk, slen;
      logic [31:0] entry;
      logic        last;
      if (r.action == ACT_LOAD) begin
        block_map[r.map_index] = r.entry_value;
        expect_segment(K_ACK, 0, 0, r.map_index, 1'b1);
        return;
      end
      if (r.action == ACT_SETC) begin
        alloc_count = (r.entry_value > MAP_BLOCKS) ? 13'(MAP_BLOCKS) : r.entry_value[12:0];
        expect_segment(K_ACK, 0, 0, 0, 1'b1);
        return;
      end
      lg    = block_log2();
      total = disk_blocks();
      bsize = 64'd1 << lg;
      if (r.byte_length == 0) begin
        expect_segment(K_ACK, 0, 0, 0, 1'b1);
        return;
      end
      first = {32'b0, r.byte_offset} >> lg;
      stop  = {32'b0, r.byte_offset} + {39'b0, r.byte_length};
      lastb = (stop - 1) >> lg;
      if (lastb >= total || lastb - first + 1 > SEG_LIMIT) begin
        expect_segment(K_ERR, 0, 0, first, 1'b1);
        return;
      end
      pos = {32'b0, r.byte_offset};
      seg = 0;
      while (pos < stop) begin
        blk   = pos >> lg;
        inblk = pos & (bsize - 1);
        slen  = bsize - inblk;
        if (slen > stop - pos) slen = stop - pos;
        last  = (pos + slen >= stop);
        entry = block_map[blk[11:0]];
        if (r.action == ACT_READ) begin
          if (entry == FREE_MARK) expect_segment(K_HOLE, 0, slen, blk, last);
          else if (entry == ZERO_MARK) expect_segment(K_ZFILL, 0, slen, blk, last);
          else expect_segment(K_RMAP, image_offset(entry, lg, inblk), slen, blk, last);
        end else if (entry == FREE_MARK || entry == ZERO_MARK) begin
          if (seg < 16 && r.zero_mask[seg]) begin
            block_map[blk[11:0]] = ZERO_MARK;
            expect_segment(K_MZERO, 0, slen, blk, last);
          end else if (alloc_count >= total) begin
            expect_segment(K_ERR, 0, 0, blk, 1'b1);
            return;
          end else begin
            block_map[blk[11:0]] = {19'b0, alloc_count};
            alloc_count = alloc_count + 13'd1;
            expect_segment(K_ALLOC, image_offset({19'b0, alloc_count - 13'd1}, lg, inblk),
                           slen, blk, last);
          end
        end else begin
          expect_segment(K_WMAP, image_offset(entry, lg, inblk), slen, blk, last);
        end
        seg++;
        pos += slen;
      end
    endfunction

    function void check_segment(segment_t got);
      segment_t want;
      if (expected_segments.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind %0d offset %h length %0d block %0d count %0d last %0b",
                   got.kind, got.phys, got.len, got.vblk, got.count, got.last);
        return;
      end
      want = expected_segments.pop_front();
      if (got.kind !== want.kind || got.phys !== want.phys || got.len !== want.len ||
          got.vblk !== want.vblk || got.count !== want.count || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result differs: expected kind %0d offset %h length %0d block %0d count %0d last %0b",
                   want.kind, want.phys, want.len, want.vblk, want.count, want.last);
          $display("                actual   kind %0d offset %h length %0d block %0d count %0d last %0b",
                   got.kind, got.phys, got.len, got.vblk, got.count, got.last);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   quiet;
  int   rx_stall;
  int   cycles = 0;
  segment_t seen;
  segment_scoreboard sb;

  sbm_req_if req_ch ();
  sbm_res_if res_ch ();
  sbm_cfg_if cfg_ch ();

  sparse_block_map_translator_top u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int pause_length();
    int p;
    if (quiet) return 0;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      rx_stall <= 0;
    end else if (rx_stall > 0) begin
      res_ch.ready <= 1'b0;
      rx_stall <= rx_stall - 1;
    end else begin
      res_ch.ready <= 1'b1;
      rx_stall <= pause_length();
    end
  end

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      seen.kind  = res_ch.segment_kind;
      seen.phys  = res_ch.physical_offset;
      seen.len   = res_ch.segment_length;
      seen.vblk  = res_ch.virtual_block;
      seen.count = res_ch.allocated_count;
      seen.last  = res_ch.last_segment;
      sb.check_segment(seen);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic map_req_t make_req(act_t act, logic [31:0] off, logic [24:0] len,
                                        logic [15:0] mask, logic [11:0] idx,
                                        logic [31:0] val);
    map_req_t r;
    r.action      = act;
    r.byte_offset = off;
    r.byte_length = len;
    r.zero_mask   = mask;
    r.map_index   = idx;
    r.entry_value = val;
    return r;
  endfunction

  function automatic map_req_t random_request();
    int unsigned lg, total, p, q, nseg;
    logic [63:0] bsize, s, e, first, len;
    logic [31:0] val;
    logic [15:0] mask;
    logic [11:0] idx;
    lg    = sb.block_log2();
    total = sb.disk_blocks();
    bsize = 64'd1 << lg;
    p = $urandom_range(0, 99);
    if (p < 8) begin
      q = $urandom_range(0, 5);
      val = (q == 0) ? FREE_MARK : (q == 1) ? ZERO_MARK : (q == 2) ? $urandom() :
            $urandom_range(0, total + 4);
      idx = ($urandom_range(0, 9) < 7) ? 12'($urandom_range(0, (total > 0) ? total - 1 : 0)) :
            12'($urandom_range(0, MAP_BLOCKS - 1));
      return make_req(ACT_LOAD, $urandom(), 25'($urandom_range(0, 16777216)),
                      16'($urandom_range(0, 65535)), idx, val);
    end
    if (p < 13) begin
      q = $urandom_range(0, 3);
      val = (q == 0) ? $urandom() : (q == 1) ? 32'd0 : $urandom_range(0, total);
      return make_req(ACT_SETC, $urandom(), 25'($urandom_range(0, 16777216)),
                      16'($urandom_range(0, 65535)), 12'($urandom()), val);
    end
    if (p < 22)
      return make_req(act_t'($urandom_range(0, 1)), $urandom(),
                      25'($urandom_range(0, 16777216)), 16'($urandom_range(0, 65535)),
                      12'($urandom()), $urandom());
    q = $urandom_range(0, 99);
    nseg = (q < 70) ? $urandom_range(1, 4) : (q < 95) ? $urandom_range(5, 16) :
           $urandom_range(17, 20);
    if (total > nseg && $urandom_range(0, 9) != 0) first = $urandom_range(0, total - nseg);
    else first = $urandom_range(0, (total > 0) ? total - 1 : 0);
    s = $urandom_range(0, 32'(bsize - 1));
    e = (nseg == 1) ? $urandom_range(32'(s + 1), 32'(bsize)) : $urandom_range(1, 32'(bsize));
    len = (nseg - 1) * bsize + e - s;
    if (len > 16777216) len = 16777216;
    q = $urandom_range(0, 3);
    mask = (q == 0) ? 16'h0000 : (q == 1) ? 16'hFFFF : 16'($urandom_range(0, 65535));
    return make_req(act_t'($urandom_range(0, 1)), 32'(first * bsize + s), 25'(len), mask,
                    12'($urandom()), $urandom());
  endfunction

  task automatic submit_request(map_req_t r);
    int gap;
    req_ch.valid       <= 1'b1;
    req_ch.action      <= r.action;
    req_ch.byte_offset <= r.byte_offset;
    req_ch.byte_length <= r.byte_length;
    req_ch.zero_mask   <= r.zero_mask;
    req_ch.map_index   <= r.map_index;
    req_ch.entry_value <= r.entry_value;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(r);
    gap = pause_length();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_for_idle();
    req_ch.valid <= 1'b0;
    while (sb.expected_segments.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic program_map_geometry(logic [4:0] lg, logic [31:0] doff, logic [12:0] btot);
    cfg_idx_t    idx;
    logic [31:0] val;
    for (int i = 0; i < 3; i++) begin
      idx = cfg_idx_t'(i);
      val = (i == 0) ? {27'b0, lg} : (i == 1) ? doff : {19'b0, btot};
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx;
      cfg_ch.data  <= val;
      do @(posedge clk); while (!cfg_ch.ready);
      sb.set_register(idx, val);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    map_req_t directed [$];
    int n;
    sb = new();
    quiet = 1'b0;
    rst <= 1'b1;
    req_ch.valid       <= 1'b0;
    req_ch.action      <= ACT_READ;
    req_ch.byte_offset <= '0;
    req_ch.byte_length <= '0;
    req_ch.zero_mask   <= '0;
    req_ch.map_index   <= '0;
    req_ch.entry_value <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= CFG_BSIZE;
    cfg_ch.data        <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    program_map_geometry(5'd12, 32'h1000_0000, 13'd40);
    directed.push_back(make_req(ACT_READ, 0, 0, 0, 0, 0));
    directed.push_back(make_req(ACT_READ, 100, 50, 0, 0, 0));
    directed.push_back(make_req(ACT_WRITE, 0, 4096, 16'h0001, 0, 0));
    directed.push_back(make_req(ACT_READ, 0, 4096, 0, 0, 0));
    directed.push_back(make_req(ACT_WRITE, 2048, 8192, 16'h0000, 0, 0));
    directed.push_back(make_req(ACT_READ, 1000, 12000, 0, 0, 0));
    directed.push_back(make_req(ACT_WRITE, 4100, 100, 16'h0000, 0, 0));
    directed.push_back(make_req(ACT_LOAD, 0, 0, 0, 12'd7, 32'hFFFF_FF00));
    directed.push_back(make_req(ACT_READ, 7 * 4096 + 5, 10, 0, 0, 0));
    directed.push_back(make_req(ACT_LOAD, 0, 0, 0, 12'd6, ZERO_MARK));
    directed.push_back(make_req(ACT_READ, 6 * 4096, 4096, 0, 0, 0));
    directed.push_back(make_req(ACT_LOAD, 0, 0, 0, 12'd5, FREE_MARK));
    directed.push_back(make_req(ACT_READ, 40 * 4096, 1, 0, 0, 0));
    directed.push_back(make_req(ACT_READ, 39 * 4096, 4097, 0, 0, 0));
    directed.push_back(make_req(ACT_READ, 0, 17 * 4096, 0, 0, 0));
    directed.push_back(make_req(ACT_READ, 32'hFFFF_FFFF, 25'd16777216, 16'hFFFF, 0, 0));
    directed.push_back(make_req(ACT_WRITE, 16 * 4096, 16 * 4096, 16'hAAAA, 0, 0));
    directed.push_back(make_req(ACT_READ, 16 * 4096 + 1, 16 * 4096 - 1, 0, 0, 0));
    directed.push_back(make_req(ACT_SETC, 0, 0, 0, 0, 32'd38));
    directed.push_back(make_req(ACT_WRITE, 8 * 4096, 4 * 4096, 16'h0000, 0, 0));
    directed.push_back(make_req(ACT_WRITE, 12 * 4096, 4096, 16'h0001, 0, 0));
    directed.push_back(make_req(ACT_SETC, 0, 0, 0, 0, 32'hFFFF_FFFF));
    directed.push_back(make_req(ACT_SETC, 0, 0, 0, 0, 32'd0));
    directed.push_back(make_req(ACT_LOAD, 0, 0, 0, 12'd4095, 32'h0000_1234));
    directed.push_back(make_req(ACT_READ, 32'hFFFF_FFFF, 0, 0, 0, 0));
    foreach (directed[i]) submit_request(directed[i]);
    wait_for_idle();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin program_map_geometry(5'd20, 32'h0, 13'd4096); n = 20; end
        1: begin program_map_geometry(5'd9, 32'hFFFF_FFFF, 13'd8191); n = 20; end
        2: begin program_map_geometry(5'd0, $urandom(), 13'd64); n = 15; end
        3: begin program_map_geometry(5'd31, $urandom(), 13'd0); n = 6; end
        4: begin program_map_geometry(5'd14, $urandom(), 13'd300); n = 20; end
        default: begin program_map_geometry(5'd10, 32'h0, 13'd20); n = 20; end
      endcase
      quiet = (ph == 0);
      for (int i = 0; i < n; i++) begin
        // Midway through phase 1, hold off new requests until the block has returned everything.
        if (ph == 1 && i == 12) wait_for_idle();
        submit_request(random_request());
      end
      wait_for_idle();
    end

    if (sb.mismatches == 0 && sb.expected_segments.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/sbm_pkg.sv
rtl/core/sbm_if.sv
rtl/core/sbm_addu.sv
rtl/core/sbm_map.sv
rtl/core/sbm_ctrl.sv
rtl/core/sparse_block_map_translator_top.sv
test/tb.sv
